>>> hdl/hpm_pkg.sv
// types and constants shared by the hot-plug slot presence manager
package hpm_pkg;

    typedef enum logic [1:0] {
        REQ_PROBE       = 2'd0,
        REQ_CLAIM_TYPED = 2'd1,
        REQ_CLAIM_ANY   = 2'd2,
        REQ_RELEASE     = 2'd3
    } t_req;

    typedef enum logic [1:0] {
        COND_EMPTY   = 2'd0,
        COND_READY   = 2'd1,
        COND_INVALID = 2'd2,
        COND_CLAIMED = 2'd3
    } t_cond;

    typedef enum logic [2:0] {
        EV_NONE     = 3'd0,
        EV_INSERTED = 3'd1,
        EV_REMOVED  = 3'd2,
        EV_INVALID  = 3'd3,
        EV_CLAIMED  = 3'd4,
        EV_RELEASED = 3'd5
    } t_event;

    typedef enum logic [1:0] {
        CFG_DEBOUNCE_LIMIT     = 2'd0,
        CFG_READ_ATTEMPT_LIMIT = 2'd1,
        CFG_CAMERA_TYPE_CODE   = 2'd2
    } t_cfg_idx;

    localparam logic [7:0] DEBOUNCE_LIMIT_RST     = 8'd3;
    localparam logic [7:0] READ_ATTEMPT_LIMIT_RST = 8'd3;
    localparam logic [7:0] CAMERA_TYPE_CODE_RST   = 8'd1;
    localparam logic [7:0] INVALID_COUNT_MAX      = 8'hFF;

    typedef struct packed {
        logic [7:0] debounce_limit;
        logic [7:0] read_attempt_limit;
        logic [7:0] camera_type_code;
    } t_cfg;

    typedef struct packed {
        t_req       req_type;
        logic       slot_index;
        logic       probe_present;
        logic       read_ok;
        logic [7:0] read_board_type;
        logic [7:0] claim_type;
    } t_item;

    typedef struct packed {
        logic        status;
        t_event      event_code;
        t_cond       slot_condition;
        logic [7:0]  stored_board_type;
        logic [15:0] generation_count;
        logic [7:0]  retry_count;
    } t_result;

endpackage

>>> hdl/hpm_cfg_regs.sv
// configuration registers of the hot-plug slot presence manager
module hpm_cfg_regs
    import hpm_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_valid,
    output logic       o_cfg_ready,
    input  logic [1:0] i_cfg_index,
    input  logic [7:0] i_cfg_data,
    output t_cfg       o_cfg
);

    t_cfg r_cfg;

    assign o_cfg_ready = 1'b1;
    assign o_cfg       = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.debounce_limit     <= DEBOUNCE_LIMIT_RST;
            r_cfg.read_attempt_limit <= READ_ATTEMPT_LIMIT_RST;
            r_cfg.camera_type_code   <= CAMERA_TYPE_CODE_RST;
        end else if (i_cfg_valid) begin
            // a word to an unknown index is taken and dropped
            case (i_cfg_index)
                CFG_DEBOUNCE_LIMIT:     r_cfg.debounce_limit     <= i_cfg_data;
                CFG_READ_ATTEMPT_LIMIT: r_cfg.read_attempt_limit <= i_cfg_data;
                CFG_CAMERA_TYPE_CODE:   r_cfg.camera_type_code   <= i_cfg_data;
                default: ;
            endcase
        end
    end

endmodule

>>> hdl/hpm_core.sv
// per-slot state and the combinational update for one registered item
module hpm_core
    import hpm_pkg::*;
#(
    parameter int NUM_SLOTS = 2
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_fire,
    input  t_item   i_item,
    input  t_cfg    i_cfg,
    output t_result o_result
);

    localparam int SLOT_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;

    t_cond       r_cond    [NUM_SLOTS];
    logic        r_stable  [NUM_SLOTS];
    logic        r_cand    [NUM_SLOTS];
    logic [7:0]  r_cnt     [NUM_SLOTS];
    logic [7:0]  r_inv     [NUM_SLOTS];
    logic        r_claimed [NUM_SLOTS];
    logic [7:0]  r_board   [NUM_SLOTS];
    logic [15:0] r_gen     [NUM_SLOTS];

    logic [SLOT_W-1:0] w_idx;
    logic              w_in_range;

    t_cond       n_cond;
    logic        n_stable;
    logic        n_cand;
    logic [7:0]  n_cnt;
    logic [7:0]  n_inv;
    logic        n_claimed;
    logic [7:0]  n_board;
    logic [15:0] n_gen;
    logic        w_status;
    t_event      w_event;
    logic        w_frozen;
    logic        w_publish;
    logic        w_refuse;

    assign w_idx      = SLOT_W'(i_item.slot_index);
    assign w_in_range = (32'(w_idx) < NUM_SLOTS);

    // probing stops on a claimed slot, or while slot 0 holds a claimed camera
    assign w_frozen = r_claimed[w_idx] ||
                      (r_claimed[0] && (r_board[0] == i_cfg.camera_type_code));

    always_comb begin
        n_cond    = r_cond[w_idx];
        n_stable  = r_stable[w_idx];
        n_cand    = r_cand[w_idx];
        n_cnt     = r_cnt[w_idx];
        n_inv     = r_inv[w_idx];
        n_claimed = r_claimed[w_idx];
        n_board   = r_board[w_idx];
        n_gen     = r_gen[w_idx];
        w_status  = 1'b0;
        w_event   = EV_NONE;
        w_publish = 1'b0;
        w_refuse  = 1'b0;

        case (i_item.req_type)
            REQ_PROBE: begin
                if (!w_frozen) begin
                    if (i_item.probe_present != r_cand[w_idx]) begin
                        n_cand = i_item.probe_present;
                        n_cnt  = 8'd1;
                    end else if (r_cnt[w_idx] < i_cfg.debounce_limit) begin
                        n_cnt = r_cnt[w_idx] + 8'd1;
                    end
                    if (n_cnt >= i_cfg.debounce_limit) begin
                        w_publish = (i_item.probe_present != r_stable[w_idx]) ||
                                    (i_item.probe_present &&
                                     (r_cond[w_idx] == COND_INVALID) &&
                                     (r_inv[w_idx] < i_cfg.read_attempt_limit));
                    end
                    if (w_publish) begin
                        n_gen    = r_gen[w_idx] + 16'd1;
                        n_board  = 8'd0;
                        n_stable = i_item.probe_present;
                        if (!i_item.probe_present) begin
                            n_cond  = COND_EMPTY;
                            n_inv   = 8'd0;
                            w_event = EV_REMOVED;
                        end else if (i_item.read_ok) begin
                            n_board = i_item.read_board_type;
                            n_cond  = COND_READY;
                            n_inv   = 8'd0;
                            w_event = EV_INSERTED;
                        end else begin
                            n_cond = COND_INVALID;
                            if (r_inv[w_idx] != INVALID_COUNT_MAX) begin
                                n_inv = r_inv[w_idx] + 8'd1;
                            end
                            w_event = EV_INVALID;
                        end
                    end
                end
            end
            REQ_CLAIM_TYPED, REQ_CLAIM_ANY: begin
                w_refuse = r_claimed[w_idx] ||
                           ((i_item.req_type == REQ_CLAIM_TYPED) &&
                            ((r_cond[w_idx] != COND_READY) ||
                             (r_board[w_idx] != i_item.claim_type)));
                if (w_refuse) begin
                    w_status = 1'b1;
                end else begin
                    n_claimed = 1'b1;
                    n_cond    = COND_CLAIMED;
                    n_gen     = r_gen[w_idx] + 16'd1;
                    w_event   = EV_CLAIMED;
                end
            end
            REQ_RELEASE: begin
                if (r_claimed[w_idx]) begin
                    n_claimed = 1'b0;
                    n_cond    = COND_READY;
                    n_gen     = r_gen[w_idx] + 16'd1;
                    n_cnt     = 8'd0;
                    w_event   = EV_RELEASED;
                end
            end
            default: ;
        endcase

        if (w_in_range) begin
            o_result.status            = w_status;
            o_result.event_code        = w_event;
            o_result.slot_condition    = n_cond;
            o_result.stored_board_type = n_board;
            o_result.generation_count  = n_gen;
            o_result.retry_count       = n_inv;
        end else begin
            o_result.status            = 1'b1;
            o_result.event_code        = EV_NONE;
            o_result.slot_condition    = COND_EMPTY;
            o_result.stored_board_type = 8'd0;
            o_result.generation_count  = 16'd0;
            o_result.retry_count       = 8'd0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_SLOTS; i++) begin
                r_cond[i]    <= COND_EMPTY;
                r_stable[i]  <= 1'b0;
                r_cand[i]    <= 1'b0;
                r_cnt[i]     <= 8'd0;
                r_inv[i]     <= 8'd0;
                r_claimed[i] <= 1'b0;
                r_board[i]   <= 8'd0;
                r_gen[i]     <= 16'd0;
            end
        end else if (i_fire && w_in_range) begin
            r_cond[w_idx]    <= n_cond;
            r_stable[w_idx]  <= n_stable;
            r_cand[w_idx]    <= n_cand;
            r_cnt[w_idx]     <= n_cnt;
            r_inv[w_idx]     <= n_inv;
            r_claimed[w_idx] <= n_claimed;
            r_board[w_idx]   <= n_board;
            r_gen[w_idx]     <= n_gen;
        end
    end

endmodule

>>> hdl/hotplug_slot_presence_manager.sv
// top level: input register, slot update core and result register
// an accepted word waits in the input register; its result is stored in the result register once that is free
// throughput: one item per cycle while each result is taken, set by the combinational slot update
// the input stage takes a new word while a result waits to be taken only if the input register is empty
// reset: synchronous, active low; clears all slot state and loads the
// default limits (debounce 3, read attempts 3, camera type 1)
module hotplug_slot_presence_manager
    import hpm_pkg::*;
#(
    parameter int NUM_SLOTS = 2
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [1:0]  i_req_type,
    input  logic        i_slot_index,
    input  logic        i_probe_present,
    input  logic        i_read_ok,
    input  logic [7:0]  i_read_board_type,
    input  logic [7:0]  i_claim_type,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic        o_status,
    output logic [2:0]  o_event_code,
    output logic [1:0]  o_slot_condition,
    output logic [7:0]  o_stored_board_type,
    output logic [15:0] o_generation_count,
    output logic [7:0]  o_retry_count,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [7:0]  i_cfg_data
);

    t_cfg    w_cfg;
    t_item   n_item;
    t_item   r_item;
    logic    r_in_valid;
    t_result w_result;
    t_result r_result;
    logic    r_out_valid;
    logic    w_out_free;
    logic    w_fire;

    assign n_item.req_type        = t_req'(i_req_type);
    assign n_item.slot_index      = i_slot_index;
    assign n_item.probe_present   = i_probe_present;
    assign n_item.read_ok         = i_read_ok;
    assign n_item.read_board_type = i_read_board_type;
    assign n_item.claim_type      = i_claim_type;

    assign w_out_free = !r_out_valid || i_out_ready;
    assign w_fire     = r_in_valid && w_out_free;
    assign o_in_ready = !r_in_valid || w_out_free;

    hpm_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (w_cfg)
    );

    hpm_core #(
        .NUM_SLOTS (NUM_SLOTS)
    ) u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_fire   (w_fire),
        .i_item   (r_item),
        .i_cfg    (w_cfg),
        .o_result (w_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_in_ready) begin
                r_in_valid <= i_in_valid;
            end
            if (w_out_free) begin
                r_out_valid <= r_in_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_item <= n_item;
        end
        if (w_fire) begin
            r_result <= w_result;
        end
    end

    assign o_out_valid         = r_out_valid;
    assign o_status            = r_result.status;
    assign o_event_code        = r_result.event_code;
    assign o_slot_condition    = r_result.slot_condition;
    assign o_stored_board_type = r_result.stored_board_type;
    assign o_generation_count  = r_result.generation_count;
    assign o_retry_count       = r_result.retry_count;

endmodule

>>> test/hotplug_slot_presence_manager_test.sv
// testbench for the hot-plug slot presence manager: directed and random requests checked
module hotplug_slot_presence_manager_test
    import hpm_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    // tracks every slot's state and the status words it should produce
    class slot_status_tracker;
        logic [7:0]  debounce_limit;
        logic [7:0]  attempt_limit;
        logic [7:0]  camera_code;
        t_cond       cond [2];
        logic        stable [2];
        logic        cand [2];
        logic [7:0]  cand_cnt [2];
        logic [7:0]  bad_reads [2];
        logic        claimed [2];
        logic [7:0]  board [2];
        logic [15:0] gen [2];
        t_result     awaited_status [$];
        int          errors;

        function new();
            debounce_limit = DEBOUNCE_LIMIT_RST;
            attempt_limit  = READ_ATTEMPT_LIMIT_RST;
            camera_code    = CAMERA_TYPE_CODE_RST;
            errors         = 0;
            for (int s = 0; s < 2; s++) begin
                cond[s]      = COND_EMPTY;
                stable[s]    = 1'b0;
                cand[s]      = 1'b0;
                cand_cnt[s]  = 8'd0;
                bad_reads[s] = 8'd0;
                claimed[s]   = 1'b0;
                board[s]     = 8'd0;
                gen[s]       = 16'd0;
            end
        endfunction

        function void set_register(t_cfg_idx idx, logic [7:0] value);
            case (idx)
                CFG_DEBOUNCE_LIMIT:     debounce_limit = value;
                CFG_READ_ATTEMPT_LIMIT: attempt_limit  = value;
                CFG_CAMERA_TYPE_CODE:   camera_code    = value;
                default: ;
            endcase
        endfunction

        function t_event probe(int s, logic present, logic ok, logic [7:0] rtype);
            logic publish;
            publish = 1'b0;
            // a claimed slot stops its own scanning; a claimed camera in slot 0 stops all scanning
            if (claimed[s] || (claimed[0] && board[0] == camera_code))
                return EV_NONE;
            if (present != cand[s]) begin
                cand[s]     = present;
                cand_cnt[s] = 8'd1;
            end else if (cand_cnt[s] < debounce_limit) begin
                cand_cnt[s] = cand_cnt[s] + 8'd1;
            end
            if (cand_cnt[s] >= debounce_limit)
                publish = (present != stable[s]) ||
                          (present && cond[s] == COND_INVALID && bad_reads[s] < attempt_limit);
            if (!publish)
                return EV_NONE;
            gen[s]    = gen[s] + 16'd1;
            board[s]  = 8'd0;
            stable[s] = present;
            if (!present) begin
                cond[s]      = COND_EMPTY;
                bad_reads[s] = 8'd0;
                return EV_REMOVED;
            end
            if (ok) begin
                board[s]     = rtype;
                cond[s]      = COND_READY;
                bad_reads[s] = 8'd0;
                return EV_INSERTED;
            end
            cond[s] = COND_INVALID;
            if (bad_reads[s] != INVALID_COUNT_MAX)
                bad_reads[s] = bad_reads[s] + 8'd1;
            return EV_INVALID;
        endfunction

        function void note_request(t_item it);
            t_result r;
            int      s;
            s            = int'(it.slot_index);
            r.status     = 1'b0;
            r.event_code = EV_NONE;
            case (it.req_type)
                REQ_PROBE: begin
                    r.event_code = probe(s, it.probe_present, it.read_ok, it.read_board_type);
                end
                REQ_CLAIM_TYPED, REQ_CLAIM_ANY: begin
                    if (claimed[s] || (it.req_type == REQ_CLAIM_TYPED &&
                        (cond[s] != COND_READY || board[s] != it.claim_type))) begin
                        r.status = 1'b1;
                    end else begin
                        claimed[s]   = 1'b1;
                        cond[s]      = COND_CLAIMED;
                        gen[s]       = gen[s] + 16'd1;
                        r.event_code = EV_CLAIMED;
                    end
                end
                default: begin
                    if (claimed[s]) begin
                        claimed[s]   = 1'b0;
                        cond[s]      = COND_READY;
                        gen[s]       = gen[s] + 16'd1;
                        cand_cnt[s]  = 8'd0;
                        r.event_code = EV_RELEASED;
                    end
                end
            endcase
            r.slot_condition    = cond[s];
            r.stored_board_type = board[s];
            r.generation_count  = gen[s];
            r.retry_count       = bad_reads[s];
            awaited_status.push_back(r);
        endfunction

        function void compare_field(string field, logic [15:0] want, logic [15:0] got);
            if (got !== want) begin
                $display("%0t: %s mismatch, expected %0h actual %0h", $time, field, want, got);
                errors++;
            end
        endfunction

        function void check_status(t_result got);
            t_result want;
            if (awaited_status.size() == 0) begin
                $display("%0t: unexpected result word, expected none actual %h", $time, got);
                errors++;
                return;
            end
            want = awaited_status.pop_front();
            compare_field("status", 16'(want.status), 16'(got.status));
            compare_field("event_code", 16'(want.event_code), 16'(got.event_code));
            compare_field("slot_condition", 16'(want.slot_condition),
                          16'(got.slot_condition));
            compare_field("stored_board_type", 16'(want.stored_board_type),
                          16'(got.stored_board_type));
            compare_field("generation_count", want.generation_count, got.generation_count);
            compare_field("retry_count", 16'(want.retry_count), 16'(got.retry_count));
        endfunction

        function int pending();
            return awaited_status.size();
        endfunction
    endclass

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        i_in_valid;
    logic        o_in_ready;
    logic [1:0]  i_req_type;
    logic        i_slot_index;
    logic        i_probe_present;
    logic        i_read_ok;
    logic [7:0]  i_read_board_type;
    logic [7:0]  i_claim_type;
    logic        o_out_valid;
    logic        i_out_ready;
    logic        o_status;
    logic [2:0]  o_event_code;
    logic [1:0]  o_slot_condition;
    logic [7:0]  o_stored_board_type;
    logic [15:0] o_generation_count;
    logic [7:0]  o_retry_count;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [1:0]  i_cfg_index;
    logic [7:0]  i_cfg_data;

    slot_status_tracker tracker;
    logic               tx_burst;

    hotplug_slot_presence_manager #(.NUM_SLOTS(2)) u_dut (.*);

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    initial begin
        #2_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

    always @(posedge i_clk) begin
        t_item   word_in;
        t_result word_out;
        if (i_rst_n) begin
            if (o_out_valid && i_out_ready) begin
                word_out.status            = o_status;
                word_out.event_code        = t_event'(o_event_code);
                word_out.slot_condition    = t_cond'(o_slot_condition);
                word_out.stored_board_type = o_stored_board_type;
                word_out.generation_count  = o_generation_count;
                word_out.retry_count       = o_retry_count;
                tracker.check_status(word_out);
            end
            if (i_in_valid && o_in_ready) begin
                word_in.req_type        = t_req'(i_req_type);
                word_in.slot_index      = i_slot_index;
                word_in.probe_present   = i_probe_present;
                word_in.read_ok         = i_read_ok;
                word_in.read_board_type = i_read_board_type;
                word_in.claim_type      = i_claim_type;
                tracker.note_request(word_in);
            end
        end
    end

    // result side: random stalls, bursts with none, and two long hold-offs
    initial begin : result_sink
        int   stall;
        int   taken;
        logic rx_burst;
        taken       = 0;
        rx_burst    = 1'b0;
        i_out_ready = 1'b0;
        forever begin
            if ($urandom_range(0, 39) == 0)
                rx_burst = !rx_burst;
            stall = rx_burst ? 0 : $urandom_range(0, 6);
            // long hold so the input stage fills and backs up
            if (taken == 80 || taken == 650)
                stall = 200;
            @(negedge i_clk);
            if (stall > 0) begin
                i_out_ready = 1'b0;
                repeat (stall) @(negedge i_clk);
            end
            i_out_ready = 1'b1;
            do @(posedge i_clk); while (o_out_valid !== 1'b1);
            taken++;
        end
    end

    // called at a falling edge; returns at the edge that accepts the word
    task automatic send_request(input t_item it);
        int gap;
        if ($urandom_range(0, 39) == 0)
            tx_burst = !tx_burst;
        gap = tx_burst ? 0 : $urandom_range(0, 6);
        if (gap > 0) begin
            i_in_valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_req_type        = it.req_type;
        i_slot_index      = it.slot_index;
        i_probe_present   = it.probe_present;
        i_read_ok         = it.read_ok;
        i_read_board_type = it.read_board_type;
        i_claim_type      = it.claim_type;
        i_in_valid        = 1'b1;
        do @(posedge i_clk); while (o_in_ready !== 1'b1);
    endtask

    task automatic send_word(input t_req req, input logic slot, input logic present,
                             input logic ok, input logic [7:0] rtype,
                             input logic [7:0] ctype);
        t_item it;
        it.req_type        = req;
        it.slot_index      = slot;
        it.probe_present   = present;
        it.read_ok         = ok;
        it.read_board_type = rtype;
        it.claim_type      = ctype;
        @(negedge i_clk);
        send_request(it);
    endtask

    task automatic load_register(input t_cfg_idx idx, input logic [7:0] value);
        @(negedge i_clk);
        i_cfg_index = idx;
        i_cfg_data  = value;
        i_cfg_valid = 1'b1;
        do @(posedge i_clk); while (o_cfg_ready !== 1'b1);
        tracker.set_register(idx, value);
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    task automatic drain();
        @(negedge i_clk);
        i_in_valid = 1'b0;
        while (tracker.pending() != 0)
            @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    // probes come in runs of equal presence so the debounce actually settles
    task automatic run_phase(input int count, input int ok_pct, input int flip_pct,
                             input int max_run);
        t_item it;
        int    pick;
        int    other_pct;
        int    run_left;
        logic  run_slot;
        logic  run_pres;
        run_left  = 0;
        run_slot  = 1'b0;
        run_pres  = 1'b0;
        other_pct = (max_run > 50) ? 5 : 20;
        for (int n = 0; n < count; n++) begin
            @(negedge i_clk);
            it.req_type      = t_req'($urandom_range(0, 3));
            it.slot_index    = 1'($urandom_range(0, 1));
            it.probe_present = 1'($urandom_range(0, 1));
            it.read_ok       = ($urandom_range(0, 99) < ok_pct);
            it.claim_type    = 8'($urandom_range(0, 255));
            case ($urandom_range(0, 4))
                0:       it.read_board_type = 8'h00;
                1:       it.read_board_type = 8'hFF;
                2:       it.read_board_type = tracker.camera_code;
                3:       it.read_board_type = 8'h01;
                default: it.read_board_type = 8'($urandom_range(0, 255));
            endcase
            pick = $urandom_range(0, 99);
            if (pick < other_pct / 2) begin
                it.req_type = REQ_CLAIM_TYPED;
                if ($urandom_range(0, 3) != 0)
                    it.claim_type = tracker.board[it.slot_index];
            end else if (pick < (other_pct * 3) / 4) begin
                it.req_type = REQ_CLAIM_ANY;
            end else if (pick < other_pct) begin
                it.req_type = REQ_RELEASE;
            end else begin
                it.req_type = REQ_PROBE;
                if (run_left == 0) begin
                    run_slot = 1'($urandom_range(0, 1));
                    run_pres = ($urandom_range(0, 99) < flip_pct) ?
                               !tracker.stable[run_slot] : tracker.stable[run_slot];
                    run_left = $urandom_range(0, 1) ? max_run : $urandom_range(1, max_run);
                end
                run_left--;
                it.slot_index    = run_slot;
                // an occasional glitch breaks the run
                it.probe_present = (max_run < 50 && $urandom_range(0, 19) == 0) ?
                                   !run_pres : run_pres;
            end
            send_request(it);
        end
    endtask

    initial begin : stimulus
        tracker           = new();
        tx_burst          = 1'b0;
        i_rst_n           = 1'b0;
        i_in_valid        = 1'b0;
        i_req_type        = REQ_PROBE;
        i_slot_index      = 1'b0;
        i_probe_present   = 1'b0;
        i_read_ok         = 1'b0;
        i_read_board_type = 8'd0;
        i_claim_type      = 8'd0;
        i_cfg_valid       = 1'b0;
        i_cfg_index       = CFG_DEBOUNCE_LIMIT;
        i_cfg_data        = 8'd0;
        repeat (10) @(negedge i_clk);
        i_rst_n = 1'b1;

        // release of a free slot, unidentified claim of an empty slot, frozen probe
        send_word(REQ_RELEASE,     1'b0, 1'b0, 1'b0, 8'h00, 8'h00);
        send_word(REQ_CLAIM_ANY,   1'b1, 1'b0, 1'b0, 8'h00, 8'h00);
        send_word(REQ_PROBE,       1'b1, 1'b1, 1'b1, 8'h55, 8'h00);
        send_word(REQ_RELEASE,     1'b1, 1'b0, 1'b0, 8'h00, 8'h00);
        // insert a camera in slot 0, wrong-type claim, then the claim that freezes all
        repeat (3) send_word(REQ_PROBE, 1'b0, 1'b1, 1'b1, 8'h01, 8'h00);
        send_word(REQ_CLAIM_TYPED, 1'b0, 1'b0, 1'b0, 8'h00, 8'h00);
        send_word(REQ_CLAIM_TYPED, 1'b0, 1'b0, 1'b0, 8'h00, 8'h01);
        send_word(REQ_PROBE,       1'b1, 1'b1, 1'b1, 8'hFF, 8'h00);
        send_word(REQ_CLAIM_TYPED, 1'b1, 1'b0, 1'b0, 8'h00, 8'h00);
        send_word(REQ_CLAIM_ANY,   1'b0, 1'b1, 1'b1, 8'hFF, 8'hFF);
        send_word(REQ_RELEASE,     1'b0, 1'b0, 1'b0, 8'h00, 8'h00);
        send_word(REQ_RELEASE,     1'b1, 1'b0, 1'b0, 8'h00, 8'h00);
        // bad identity reads retried up to the attempt limit
        repeat (6) send_word(REQ_PROBE, 1'b1, 1'b1, 1'b0, 8'hFF, 8'h00);
        send_word(REQ_CLAIM_TYPED, 1'b1, 1'b0, 1'b0, 8'h00, 8'hFF);
        // removal from the released slot 0
        repeat (3) send_word(REQ_PROBE, 1'b0, 1'b0, 1'b1, 8'hFF, 8'hFF);
        send_word(REQ_PROBE,       1'b1, 1'b1, 1'b1, 8'hFF, 8'h00);
        run_phase(150, 70, 60, 5);
        drain();

        // long invalid streaks drive the retry count to its top
        load_register(CFG_DEBOUNCE_LIMIT, 8'd1);
        load_register(CFG_READ_ATTEMPT_LIMIT, 8'd255);
        load_register(CFG_CAMERA_TYPE_CODE, 8'hFF);
        run_phase(350, 3, 30, 300);
        drain();

        // zero debounce: every probe is stable; zero attempts: no retries
        load_register(CFG_DEBOUNCE_LIMIT, 8'd0);
        load_register(CFG_READ_ATTEMPT_LIMIT, 8'd0);
        load_register(CFG_CAMERA_TYPE_CODE, 8'h00);
        run_phase(100, 60, 50, 3);
        drain();

        load_register(CFG_DEBOUNCE_LIMIT, 8'd255);
        load_register(CFG_READ_ATTEMPT_LIMIT, 8'd1);
        load_register(CFG_CAMERA_TYPE_CODE, 8'h80);
        run_phase(400, 60, 60, 257);
        drain();

        load_register(CFG_DEBOUNCE_LIMIT, 8'd2);
        load_register(CFG_READ_ATTEMPT_LIMIT, 8'd5);
        load_register(CFG_CAMERA_TYPE_CODE, 8'($urandom_range(0, 255)));
        run_phase(100, 50, 60, 4);
        drain();

        if (tracker.errors == 0 && tracker.pending() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

>>> files.f
hdl/hpm_pkg.sv
hdl/hpm_cfg_regs.sv
hdl/hpm_core.sv
hdl/hotplug_slot_presence_manager.sv
test/hotplug_slot_presence_manager_test.sv
